/* rtl/core/conv3x3_stream_defines.svh */
// Assertion macros shared by the 3x3 convolution block.
// Included by files that check their own logic; depends on nothing else.
`ifndef CONV3X3_STREAM_DEFINES_SVH
`define CONV3X3_STREAM_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CNV3_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("conv3x3_stream: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CNV3_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("conv3x3_stream: next-cycle check failed");

`endif

/* rtl/core/cnv3_pkg.sv */
// Shared constants, register index codes and types of the 3x3 convolution block.
// No dependencies; the other files of the block that use it refer to it by scoped names.
package cnv3_pkg;

    // Parameter defaults.
    localparam int unsigned MAX_WIDTH_DEF  = 1024;
    localparam int unsigned PIXEL_BITS_DEF = 16;
    localparam int unsigned COEF_BITS_DEF  = 8;

    // Fixed field and register widths.
    localparam int unsigned OUT_BITS     = 28;
    localparam int unsigned CFG_IDX_BITS = 3;
    localparam int unsigned IMG_W_BITS   = 11;
    localparam int unsigned IMG_H_BITS   = 12;

    // Smallest frame dimension; smaller settings act as this.
    localparam int unsigned MIN_DIM = 3;

    // Register reset values.
    localparam int unsigned KERNEL_TOP_RST   = 66049;
    localparam int unsigned KERNEL_MID_RST   = 132098;
    localparam int unsigned KERNEL_BOT_RST   = 66049;
    localparam int unsigned IMAGE_WIDTH_RST  = 1024;
    localparam int unsigned IMAGE_HEIGHT_RST = 1024;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_KERNEL_TOP   = 3'd0,
        CFG_KERNEL_MID   = 3'd1,
        CFG_KERNEL_BOT   = 3'd2,
        CFG_IMAGE_WIDTH  = 3'd3,
        CFG_IMAGE_HEIGHT = 3'd4
    } t_cfg_idx;

    // Control that travels with one window through the arithmetic pipeline.
    typedef struct packed {
        logic valid;
        logic last;
    } t_stage_ctl;

endpackage

/* rtl/core/cnv3_pix_if.sv */
// Input channel of the 3x3 convolution block: one signed pixel per word.
// Depends on cnv3_pkg for the default pixel width.
interface cnv3_pix_if #(
    parameter int unsigned PIXEL_BITS = cnv3_pkg::PIXEL_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [PIXEL_BITS-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

/* rtl/core/cnv3_res_if.sv */
// Output channel of the 3x3 convolution block: one weighted sum per word.
// Depends on cnv3_pkg for the result width.
interface cnv3_res_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [cnv3_pkg::OUT_BITS-1:0] result_value;
    logic                                 last_of_frame;

    modport source (output valid, output result_value, output last_of_frame, input ready);
    modport sink   (input valid, input result_value, input last_of_frame, output ready);
endinterface

/* rtl/core/cnv3_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module cnv3_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/core/cnv3_mac.sv */
// Arithmetic pipeline of the 3x3 convolution: products, row sums, total with
// saturation, and the output register. Depends on cnv3_pkg and cnv3_res_if.
module cnv3_mac #(
    parameter int unsigned PIXEL_BITS = cnv3_pkg::PIXEL_BITS_DEF,
    parameter int unsigned COEF_BITS  = cnv3_pkg::COEF_BITS_DEF,
    localparam int unsigned KROW_W    = 3 * COEF_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cnv3_pkg::t_stage_ctl         i_ctl,
    input  logic signed [PIXEL_BITS-1:0] i_tap [9],
    input  logic [KROW_W-1:0]            i_kernel [3],
    output logic                         o_ready,
    cnv3_res_if.source                   o_res
);
    localparam int unsigned OUT_W = cnv3_pkg::OUT_BITS;
    localparam int unsigned PW    = PIXEL_BITS + COEF_BITS;
    localparam int unsigned RW    = PW + 2;
    localparam int unsigned SW    = PW + 4;
    localparam int unsigned EW    = (SW > OUT_W) ? SW : OUT_W;

    localparam logic signed [EW-1:0] SAT_HI = {{(EW - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
    localparam logic signed [EW-1:0] SAT_LO = {{(EW - OUT_W + 1){1'b1}}, {(OUT_W - 1){1'b0}}};

    logic signed [PW-1:0]    n_prod [9];
    logic signed [PW-1:0]    r_prod [9];
    logic signed [RW-1:0]    n_rsum [3];
    logic signed [RW-1:0]    r_rsum [3];
    logic signed [SW-1:0]    sum_full;
    logic signed [EW-1:0]    sum_ext;
    logic signed [OUT_W-1:0] n_res;
    logic signed [OUT_W-1:0] r_res;
    logic                    r_v2, r_v3, r_v4;
    logic                    r_last2, r_last3, r_last4;
    logic                    en2, en3, en4;

    // Each stage loads when it is empty or its contents move on.
    assign en4     = !r_v4 || o_res.ready;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign o_ready = en2;

    // One product per tap: the row selects the kernel register, the column
    // position selects the coefficient within it.
    for (genvar gr = 0; gr < 3; gr++) begin : g_row
        for (genvar gp = 0; gp < 3; gp++) begin : g_pos
            assign n_prod[3*gr+gp] =
                PW'($signed(i_kernel[gr][gp*COEF_BITS +: COEF_BITS])) * PW'(i_tap[3*gr+gp]);
        end
    end

    // Sum of each kernel row.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_rsum[i] = RW'(r_prod[3*i]) + RW'(r_prod[3*i+1]) + RW'(r_prod[3*i+2]);
        end
    end

    // Total of the three rows, clamped to the result range.
    assign sum_full = SW'(r_rsum[0]) + SW'(r_rsum[1]) + SW'(r_rsum[2]);
    assign sum_ext  = EW'(sum_full);

    always_comb begin
        if (sum_ext > SAT_HI) begin
            n_res = SAT_HI[OUT_W-1:0];
        end else if (sum_ext < SAT_LO) begin
            n_res = SAT_LO[OUT_W-1:0];
        end else begin
            n_res = sum_ext[OUT_W-1:0];
        end
    end

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en2) begin
                r_v2 <= i_ctl.valid;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_prod  <= n_prod;
            r_last2 <= i_ctl.last;
        end
        if (en3) begin
            r_rsum  <= n_rsum;
            r_last3 <= r_last2;
        end
        if (en4) begin
            r_res   <= n_res;
            r_last4 <= r_last3;
        end
    end

    assign o_res.valid         = r_v4;
    assign o_res.result_value  = r_res;
    assign o_res.last_of_frame = r_last4;
endmodule

/* rtl/core/conv3x3_stream.sv */
// Streaming 3x3 convolution over signed pixels in raster order.
// Throughput: one pixel word per cycle unless the output stalls, set by one line store
// write and one read a cycle. Pipeline: capture, product, row sum, output registers.
// Border pixels give no word; the last interior word of a frame carries last_of_frame.
// Reset restores the kernel and frame size registers and clears all counters; the line
// store is never swept, a fill count makes unwritten entries read as zero.
module conv3x3_stream #(
    parameter int unsigned MAX_WIDTH  = cnv3_pkg::MAX_WIDTH_DEF,
    parameter int unsigned PIXEL_BITS = cnv3_pkg::PIXEL_BITS_DEF,
    parameter int unsigned COEF_BITS  = cnv3_pkg::COEF_BITS_DEF,
    localparam int unsigned KROW_W    = 3 * COEF_BITS,
    localparam int unsigned CFG_W     =
        (KROW_W > cnv3_pkg::IMG_H_BITS) ? KROW_W : cnv3_pkg::IMG_H_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cnv3_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]                  i_cfg_data,
    cnv3_pix_if.sink                          i_pix,
    cnv3_res_if.source                        o_res
);
    `include "conv3x3_stream_defines.svh"

    localparam int unsigned CW  = $clog2(MAX_WIDTH);
    localparam int unsigned HB  = cnv3_pkg::IMG_H_BITS;
    localparam int unsigned WB  = cnv3_pkg::IMG_W_BITS;
    localparam int unsigned WW  = (CW + 1 > WB) ? CW + 1 : WB;
    localparam int unsigned P   = PIXEL_BITS;
    localparam int unsigned RST_W_EFF =
        (cnv3_pkg::IMAGE_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : cnv3_pkg::IMAGE_WIDTH_RST;
    localparam logic [CW-1:0] RST_W_LAST = CW'(RST_W_EFF - 1);
    localparam logic [HB-1:0] RST_H_LAST = HB'(cnv3_pkg::IMAGE_HEIGHT_RST - 1);

    // Configuration registers; frame limits are kept as "last index" values.
    logic [KROW_W-1:0] r_kernel [3];
    logic [CW-1:0]     r_w_last;
    logic [HB-1:0]     r_h_last;
    logic [WW-1:0]     w_raw, w_eff;
    logic [HB-1:0]     h_raw;
    logic [CW-1:0]     n_w_last;
    logic [HB-1:0]     n_h_last;

    // Position, fill count and window.
    logic                 r_run;
    logic [CW-1:0]        r_col, n_col;
    logic [HB-1:0]        r_row;
    logic [CW:0]          r_fill;
    logic signed [P-1:0]  r_win [6];
    logic signed [P-1:0]  col_older, col_newer, col_pix;
    logic [2*P-1:0]       ram_rdata;
    logic                 stored_ok;
    logic                 accept, row_end, frame_end, produce;

    // Capture stage feeding the arithmetic pipeline.
    logic signed [P-1:0]  r_tap [9];
    logic                 r_v1, r_last1;
    logic                 en1, mac_ready;
    cnv3_pkg::t_stage_ctl tap_ctl;

    // Clamp the width to the legal range before it becomes a limit.
    assign w_raw = WW'(i_cfg_data[WB-1:0]);
    always_comb begin
        if (w_raw < WW'(cnv3_pkg::MIN_DIM)) begin
            w_eff = WW'(cnv3_pkg::MIN_DIM);
        end else if (w_raw > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = w_raw;
        end
    end
    assign n_w_last = CW'(w_eff - WW'(1));

    assign h_raw    = i_cfg_data[HB-1:0];
    assign n_h_last = (h_raw < HB'(cnv3_pkg::MIN_DIM)) ? HB'(cnv3_pkg::MIN_DIM - 1)
                                                       : h_raw - HB'(1);

    // Register writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel[0] <= KROW_W'(cnv3_pkg::KERNEL_TOP_RST);
            r_kernel[1] <= KROW_W'(cnv3_pkg::KERNEL_MID_RST);
            r_kernel[2] <= KROW_W'(cnv3_pkg::KERNEL_BOT_RST);
            r_w_last    <= RST_W_LAST;
            r_h_last    <= RST_H_LAST;
        end else if (i_cfg_we) begin
            unique case (cnv3_pkg::t_cfg_idx'(i_cfg_idx))
                cnv3_pkg::CFG_KERNEL_TOP:   r_kernel[0] <= i_cfg_data[KROW_W-1:0];
                cnv3_pkg::CFG_KERNEL_MID:   r_kernel[1] <= i_cfg_data[KROW_W-1:0];
                cnv3_pkg::CFG_KERNEL_BOT:   r_kernel[2] <= i_cfg_data[KROW_W-1:0];
                cnv3_pkg::CFG_IMAGE_WIDTH:  r_w_last    <= n_w_last;
                cnv3_pkg::CFG_IMAGE_HEIGHT: r_h_last    <= n_h_last;
                default: ;
            endcase
        end
    end

    // Input handshake: after reset, take a word whenever the capture stage can move on.
    assign en1         = !r_v1 || mac_ready;
    assign i_pix.ready = r_run && en1;
    assign accept      = i_pix.valid && i_pix.ready;

    // Frame position decode.
    assign row_end   = (r_col >= r_w_last);
    assign frame_end = row_end && (r_row >= r_h_last);
    assign produce   = (r_row >= HB'(2)) && (r_col >= CW'(2));

    always_comb begin
        if (!i_rst_n) begin
            n_col = '0;
        end else if (accept) begin
            n_col = row_end ? '0 : r_col + CW'(1);
        end else begin
            n_col = r_col;
        end
    end

    // Both line stores share one word per column: older half above, newer below.
    // The read is issued for the next column so its data is ready with the pixel.
    cnv3_ram #(
        .WIDTH (2 * P),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_col),
        .i_wdata ({col_newer, col_pix}),
        .i_raddr (n_col),
        .o_rdata (ram_rdata)
    );

    // Columns written since reset form a prefix; anything beyond reads as zero.
    assign stored_ok = ({1'b0, r_col} < r_fill);
    assign col_older = stored_ok ? ram_rdata[2*P-1:P] : '0;
    assign col_newer = stored_ok ? ram_rdata[P-1:0]   : '0;
    assign col_pix   = i_pix.pixel_value;

    // Counters and the fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_col  <= '0;
            r_row  <= '0;
            r_fill <= '0;
        end else begin
            r_run <= 1'b1;
            r_col <= n_col;
            if (accept) begin
                if (frame_end) begin
                    r_row <= '0;
                end else if (row_end) begin
                    r_row <= r_row + HB'(1);
                end
                if ({1'b0, r_col} == r_fill) begin
                    r_fill <= r_fill + (CW+1)'(1);
                end
            end
        end
    end

    // Window shift and capture of the nine taps of an interior pixel.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= col_older;
            r_win[4] <= col_newer;
            r_win[5] <= col_pix;
        end
        if (en1) begin
            r_tap[0] <= r_win[0];
            r_tap[1] <= r_win[3];
            r_tap[2] <= col_older;
            r_tap[3] <= r_win[1];
            r_tap[4] <= r_win[4];
            r_tap[5] <= col_newer;
            r_tap[6] <= r_win[2];
            r_tap[7] <= r_win[5];
            r_tap[8] <= col_pix;
            r_last1  <= frame_end;
        end
    end

    // Capture stage valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= accept && produce;
        end
    end

    assign tap_ctl.valid = r_v1;
    assign tap_ctl.last  = r_last1;

    cnv3_mac #(
        .PIXEL_BITS (PIXEL_BITS),
        .COEF_BITS  (COEF_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (tap_ctl),
        .i_tap    (r_tap),
        .i_kernel (r_kernel),
        .o_ready  (mac_ready),
        .o_res    (o_res)
    );

    // Checks on the position logic and the capture stage.
    `CNV3_ASSERT_NOW(a_fill_covers_col, i_clk, i_rst_n, 1'b1, ({1'b0, r_col} <= r_fill))
    `CNV3_ASSERT_NOW(a_fill_in_range, i_clk, i_rst_n, 1'b1, (r_fill <= (CW+1)'(MAX_WIDTH)))
    `CNV3_ASSERT_NEXT(a_frame_end_wraps, i_clk, i_rst_n, accept && frame_end, (r_col == '0) && (r_row == '0))
    `CNV3_ASSERT_NEXT(a_interior_captured, i_clk, i_rst_n, accept && produce, r_v1)
endmodule

/* tb/conv3x3_stream_tb.sv */
// Self-checking testbench for conv3x3_stream: drives pixel words and register writes,
// predicts every window sum and frame flag, and checks each result word in order.
// Depends on cnv3_pkg and the cnv3_pix_if and cnv3_res_if interfaces of the RTL.
module conv3x3_stream_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_W     = cnv3_pkg::MAX_WIDTH_DEF;
    localparam int unsigned PIX_W     = cnv3_pkg::PIXEL_BITS_DEF;
    localparam int unsigned COEF_W    = cnv3_pkg::COEF_BITS_DEF;
    localparam int unsigned KROW_BITS = 3 * COEF_W;
    localparam int unsigned OUT_W     = cnv3_pkg::OUT_BITS;
    localparam int unsigned IDX_W     = cnv3_pkg::CFG_IDX_BITS;
    localparam int unsigned IMW_W     = cnv3_pkg::IMG_W_BITS;
    localparam int unsigned IMH_W     = cnv3_pkg::IMG_H_BITS;
    localparam longint      SUM_HI    = (longint'(1) <<< (OUT_W - 1)) - 1;
    localparam longint      SUM_LO    = -SUM_HI - 1;

    // Register indexes that decode to nothing.
    localparam logic [IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned RANDOM_PIXELS  = 1450;
    localparam int unsigned CYCLE_LIMIT    = 400000;
    localparam int unsigned REPORT_LIMIT   = 10;

    typedef logic signed [PIX_W-1:0] t_pixel;

    typedef struct packed {
        logic signed [OUT_W-1:0] value;
        logic                    last;
    } t_window_sum;

    // Tracks line stores, window and counters, and holds the sums still owed by the block.
    class t_window_sum_tracker;
        logic [KROW_BITS-1:0] kernel_rows[3];
        logic [IMW_W-1:0] width_reg;
        logic [IMH_W-1:0] height_reg;
        t_pixel upper_line[MAX_W];
        t_pixel lower_line[MAX_W];
        t_pixel window[6];
        int unsigned col_cnt;
        int unsigned row_cnt;
        t_window_sum sums_due[$];
        int unsigned mismatches;
        int unsigned sums_matched;
        int unsigned frames_closed;

        function void clear();
            kernel_rows[0] = KROW_BITS'(cnv3_pkg::KERNEL_TOP_RST);
            kernel_rows[1] = KROW_BITS'(cnv3_pkg::KERNEL_MID_RST);
            kernel_rows[2] = KROW_BITS'(cnv3_pkg::KERNEL_BOT_RST);
            width_reg = IMW_W'(cnv3_pkg::IMAGE_WIDTH_RST);
            height_reg = IMH_W'(cnv3_pkg::IMAGE_HEIGHT_RST);
            foreach (upper_line[i]) upper_line[i] = '0;
            foreach (lower_line[i]) lower_line[i] = '0;
            foreach (window[i]) window[i] = '0;
            col_cnt = 0;
            row_cnt = 0;
            sums_due.delete();
            mismatches = 0;
            sums_matched = 0;
            frames_closed = 0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [KROW_BITS-1:0] data);
            case (idx)
                cnv3_pkg::CFG_KERNEL_TOP:   kernel_rows[0] = data;
                cnv3_pkg::CFG_KERNEL_MID:   kernel_rows[1] = data;
                cnv3_pkg::CFG_KERNEL_BOT:   kernel_rows[2] = data;
                cnv3_pkg::CFG_IMAGE_WIDTH:  width_reg = data[IMW_W-1:0];
                cnv3_pkg::CFG_IMAGE_HEIGHT: height_reg = data[IMH_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned eff_width();
            if (width_reg < cnv3_pkg::MIN_DIM) return cnv3_pkg::MIN_DIM;
            if (width_reg > MAX_W) return MAX_W;
            return 32'(width_reg);
        endfunction

        function int unsigned eff_height();
            if (height_reg < cnv3_pkg::MIN_DIM) return cnv3_pkg::MIN_DIM;
            return 32'(height_reg);
        endfunction

        function bit frame_open();
            return (col_cnt != 0) || (row_cnt != 0);
        endfunction

        // Words still needed to close the current frame under the present sizes.
        function int unsigned pixels_left_in_frame();
            int unsigned w;
            int unsigned h;
            int unsigned row_left;
            w = eff_width();
            h = eff_height();
            row_left = (col_cnt + 1 >= w) ? 1 : w - col_cnt;
            if (row_cnt + 1 >= h) return row_left;
            return row_left + (h - row_cnt - 1) * w;
        endfunction

        function longint coef(logic [KROW_BITS-1:0] row, int unsigned pos);
            logic signed [COEF_W-1:0] c;
            c = row[pos*COEF_W +: COEF_W];
            return longint'(c);
        endfunction

        // Advance the window by one accepted pixel; owe a sum for interior pixels.
        function void take_pixel(t_pixel px);
            int unsigned w;
            int unsigned h;
            int unsigned c;
            int unsigned r;
            int unsigned k;
            t_pixel column[3];
            longint acc;
            bit row_end;
            bit frame_end;
            t_window_sum owed;
            w = eff_width();
            h = eff_height();
            c = (col_cnt >= MAX_W) ? MAX_W - 1 : col_cnt;
            r = row_cnt;
            column[0] = upper_line[c];
            column[1] = lower_line[c];
            column[2] = px;
            row_end = (c + 1 >= w);
            frame_end = row_end && (r + 1 >= h);

            if (r >= 2 && c >= 2) begin
                acc = 0;
                for (k = 0; k < 3; k++) begin
                    acc += coef(kernel_rows[k], 0) * longint'(window[k]);
                    acc += coef(kernel_rows[k], 1) * longint'(window[3+k]);
                    acc += coef(kernel_rows[k], 2) * longint'(column[k]);
                end
                if (acc > SUM_HI) acc = SUM_HI;
                if (acc < SUM_LO) acc = SUM_LO;
                owed.value = acc[OUT_W-1:0];
                owed.last = frame_end;
                sums_due.push_back(owed);
            end

            for (k = 0; k < 3; k++) begin
                window[k] = window[3+k];
                window[3+k] = column[k];
            end
            upper_line[c] = column[1];
            lower_line[c] = column[2];

            if (row_end) begin
                col_cnt = 0;
                row_cnt = frame_end ? 0 : r + 1;
            end else begin
                col_cnt = c + 1;
            end
        endfunction

        function void flag_mismatch(string what);
            mismatches++;
            if (mismatches <= REPORT_LIMIT) $display("MISMATCH: %s", what);
        endfunction

        // Compare one accepted result word with the oldest owed sum.
        function void match_sum(logic signed [OUT_W-1:0] value, logic last);
            t_window_sum owed;
            if (sums_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected word: value %0d last %0b", value, last));
                return;
            end
            owed = sums_due.pop_front();
            if (value !== owed.value)
                flag_mismatch($sformatf("result_value expected %0d got %0d",
                                        owed.value, value));
            if (last !== owed.last)
                flag_mismatch($sformatf("last_of_frame expected %0b got %0b (value %0d)",
                                        owed.last, last, owed.value));
            if (value === owed.value && last === owed.last) sums_matched++;
            if (owed.last) frames_closed++;
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [IDX_W-1:0] i_cfg_idx;
    logic [KROW_BITS-1:0] i_cfg_data;

    cnv3_pix_if #(.PIXEL_BITS(PIX_W)) pix_ch ();
    cnv3_res_if sum_ch ();

    conv3x3_stream #(
        .MAX_WIDTH  (MAX_W),
        .PIXEL_BITS (PIX_W),
        .COEF_BITS  (COEF_W)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_ch),
        .o_res      (sum_ch)
    );

    t_window_sum_tracker sb;
    int unsigned src_idle_pct;
    int unsigned snk_stall_pct;
    int unsigned pixels_sent;
    int unsigned settings_used;
    int unsigned cycle_count = 0;

    // Clock.
    always #10 i_clk = ~i_clk;

    // Run guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d sums still owed",
                     cycle_count, sb.sums_due.size());
            $display("conv3x3_stream_tb NOT OK");
            $finish;
        end
    end

    // Receiver: check each accepted word, then draw the ready for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && sum_ch.valid && sum_ch.ready)
            sb.match_sum(sum_ch.result_value, sum_ch.last_of_frame);
        sum_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    task automatic set_idle_mode(input int unsigned mode);
        case (mode)
            0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1: begin src_idle_pct = 58; snk_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_stall_pct = 58; end
            default: begin src_idle_pct = 22; snk_stall_pct = 22; end
        endcase
    endtask

    // Offer one pixel word, idling first at random; valid stays high after acceptance.
    task automatic send_pixel(input t_pixel px);
        while ($urandom_range(99) < src_idle_pct) begin
            pix_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.pixel_value <= px;
        do @(posedge i_clk); while (!pix_ch.ready);
        sb.take_pixel(px);
        pixels_sent++;
    endtask

    function automatic t_pixel rand_pixel();
        case ($urandom_range(9))
            0: return {1'b1, {(PIX_W-1){1'b0}}};
            1: return {1'b0, {(PIX_W-1){1'b1}}};
            default: return t_pixel'($urandom);
        endcase
    endfunction

    // Hold the sender off until every owed sum has arrived.
    task automatic pause_for_sums();
        pix_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.sums_due.size() != 0);
    endtask

    task automatic send_run(input int unsigned count, input int pause_at);
        int unsigned i;
        for (i = 0; i < count; i++) begin
            if (int'(i) == pause_at) pause_for_sums();
            send_pixel(rand_pixel());
        end
    endtask

    // Wait until the block has gone quiet, including border pixels still in flight.
    task automatic drain();
        pause_for_sums();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [IDX_W-1:0] idx,
                           input logic [KROW_BITS-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_config(input logic [KROW_BITS-1:0] k_top,
                               input logic [KROW_BITS-1:0] k_mid,
                               input logic [KROW_BITS-1:0] k_bot,
                               input int unsigned w, input int unsigned h);
        set_reg(cnv3_pkg::CFG_KERNEL_TOP, k_top);
        set_reg(cnv3_pkg::CFG_KERNEL_MID, k_mid);
        set_reg(cnv3_pkg::CFG_KERNEL_BOT, k_bot);
        set_reg(cnv3_pkg::CFG_IMAGE_WIDTH, KROW_BITS'(w));
        set_reg(cnv3_pkg::CFG_IMAGE_HEIGHT, KROW_BITS'(h));
        settings_used++;
    endtask

    // One random phase: new settings, close any open frame, then whole frames, the last maybe broken.
    task automatic random_phase(input int unsigned phase_no);
        int unsigned w;
        int unsigned h;
        int unsigned frames;
        int unsigned f;
        int unsigned frame_px;
        drain();
        set_idle_mode(phase_no % 4);
        case ($urandom_range(9))
            0: w = $urandom_range(0, cnv3_pkg::MIN_DIM - 1);
            1: w = $urandom_range(13, 40);
            default: w = $urandom_range(cnv3_pkg::MIN_DIM, 12);
        endcase
        h = ($urandom_range(9) == 0) ? $urandom_range(0, cnv3_pkg::MIN_DIM - 1)
                                     : $urandom_range(cnv3_pkg::MIN_DIM, 8);
        load_config(KROW_BITS'($urandom), KROW_BITS'($urandom), KROW_BITS'($urandom), w, h);

        // A frame left open by the last phase finishes under the new sizes.
        if (sb.frame_open()) send_run(sb.pixels_left_in_frame(), -1);

        frame_px = sb.eff_width() * sb.eff_height();
        frames = $urandom_range(1, 3);
        for (f = 0; f < frames; f++) begin
            if ($urandom_range(4) == 0) begin
                // Broken frame: stop part way and change settings mid-frame.
                send_run($urandom_range(1, frame_px - 1), -1);
                break;
            end
            send_run(frame_px, ($urandom_range(7) == 0) ? $urandom_range(frame_px - 1) : -1);
        end
    endtask

    // Stimulus.
    initial begin
        int unsigned i;
        int unsigned phase_no;
        int unsigned random_end;
        logic [IDX_W-1:0] spare;

        sb = new;
        sb.clear();
        set_idle_mode(0);
        pixels_sent = 0;
        settings_used = 0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= cnv3_pkg::CFG_KERNEL_TOP;
        i_cfg_data <= '0;
        pix_ch.valid <= 1'b0;
        pix_ch.pixel_value <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Most negative coefficients against the most negative pixel, smallest frame.
        load_config(24'h808080, 24'h808080, 24'h808080, cnv3_pkg::MIN_DIM, cnv3_pkg::MIN_DIM);
        for (i = 0; i < 9; i++) send_pixel({1'b1, {(PIX_W-1){1'b0}}});
        drain();

        // Largest positive coefficients but a most negative centre, with alternating extreme pixels.
        load_config(24'h7F7F7F, 24'h7F807F, 24'h7F7F7F, cnv3_pkg::MIN_DIM, cnv3_pkg::MIN_DIM);
        for (i = 0; i < 9; i++)
            send_pixel(i[0] ? {1'b0, {(PIX_W-1){1'b1}}} : {1'b1, {(PIX_W-1){1'b0}}});
        drain();

        // Sizes below the minimum act as three; writes to spare indexes are ignored.
        load_config(24'h01FF02, 24'hFE0380, 24'h7F00FF, 0, 0);
        for (spare = CFG_SPARE_FIRST; spare <= CFG_SPARE_LAST; spare++) begin
            set_reg(spare, '1);
            if (spare == CFG_SPARE_LAST) break;
        end
        send_pixel('0);
        send_pixel('1);
        send_pixel(t_pixel'(1));
        send_run(6, -1);
        drain();

        // Widest rows and tallest frame, then shrink both while the frame is open.
        load_config(KROW_BITS'($urandom), KROW_BITS'($urandom), KROW_BITS'($urandom),
                    MAX_W, (1 << IMH_W) - 1);
        send_run(20, -1);
        drain();
        set_reg(cnv3_pkg::CFG_IMAGE_WIDTH, KROW_BITS'((1 << IMW_W) - 1));
        send_run(20, -1);
        drain();
        set_reg(cnv3_pkg::CFG_IMAGE_WIDTH, KROW_BITS'(cnv3_pkg::MIN_DIM));
        send_run(13, -1);
        drain();
        set_reg(cnv3_pkg::CFG_IMAGE_HEIGHT, '0);
        send_run(sb.pixels_left_in_frame(), -1);

        // Random phases cycling through the idle and stall patterns.
        phase_no = 0;
        random_end = pixels_sent + RANDOM_PIXELS;
        while (pixels_sent < random_end) begin
            random_phase(phase_no);
            phase_no++;
        end

        // Reset kernel values written back explicitly, under both idle patterns.
        drain();
        set_idle_mode(3);
        load_config(KROW_BITS'(cnv3_pkg::KERNEL_TOP_RST), KROW_BITS'(cnv3_pkg::KERNEL_MID_RST),
                    KROW_BITS'(cnv3_pkg::KERNEL_BOT_RST), 6, 4);
        if (sb.frame_open()) send_run(sb.pixels_left_in_frame(), -1);
        send_run(2 * 6 * 4, -1);
        drain();

        if (sb.sums_due.size() != 0)
            sb.flag_mismatch($sformatf("%0d sums never arrived", sb.sums_due.size()));
        $display("Sent %0d pixel words over %0d register settings; %0d sums matched,",
                 pixels_sent, settings_used, sb.sums_matched);
        $display("%0d frames closed by a flagged word, %0d mismatches.",
                 sb.frames_closed, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("conv3x3_stream_tb OK");
        end else begin
            $display("conv3x3_stream_tb NOT OK");
        end
        $finish;
    end
endmodule

/* files.f */
+incdir+rtl/core
rtl/core/cnv3_pkg.sv
rtl/core/cnv3_pix_if.sv
rtl/core/cnv3_res_if.sv
rtl/core/cnv3_ram.sv
rtl/core/cnv3_mac.sv
rtl/core/conv3x3_stream.sv
tb/conv3x3_stream_tb.sv
